// ===== hdl/xeu_pkg.sv =====
// Package for the XML entity unescaper: entity tables, queue command type.
// No dependencies; used by every module of the block.
package xeu_pkg;

  localparam int unsigned NumEnt   = 5;
  localparam int unsigned HoldMax  = 5;
  localparam int unsigned MaxOut   = 6;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] AmpChar = 8'h26;

  localparam logic [2:0] EntAmp  = 3'd0;
  localparam logic [2:0] EntLt   = 3'd1;
  localparam logic [2:0] EntGt   = 3'd2;
  localparam logic [2:0] EntQuot = 3'd3;
  localparam logic [2:0] EntApos = 3'd4;

  // One input's worth of output bytes, handed from front to back.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   fin;
  } cmd_t;

  // Byte at position pos of an entity's text, blank-padded to six bytes; zero for pos six or seven.
  function automatic logic [7:0] ent_byte(input logic [2:0] e, input logic [2:0] pos);
    logic [47:0] w;
    logic [7:0]  b;
    case (e)
      EntAmp:  w = "&amp; ";
      EntLt:   w = "&lt;  ";
      EntGt:   w = "&gt;  ";
      EntQuot: w = "&quot;";
      EntApos: w = "&apos;";
      default: w = '0;
    endcase
    b = 8'h00;
    for (int k = 0; k < 6; k++) begin
      if (pos == 3'(k)) begin
        b = w[8*(5-k) +: 8];
      end
    end
    return b;
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] e);
    logic [2:0] l;
    case (e)
      EntAmp:  l = 3'd5;
      EntLt:   l = 3'd4;
      EntGt:   l = 3'd4;
      EntQuot: l = 3'd6;
      EntApos: l = 3'd6;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] ent_char(input logic [2:0] e);
    logic [7:0] c;
    case (e)
      EntAmp:  c = 8'h26;
      EntLt:   c = 8'h3c;
      EntGt:   c = 8'h3e;
      EntQuot: c = 8'h22;
      EntApos: c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/xeu_front.sv =====
// Front end: prefix matcher that turns each accepted input byte into at most one output command.
// Depends on xeu_pkg.
module xeu_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   text_byte_i,
  input  logic         final_byte_i,
  input  logic         q_full_i,
  output logic         push_o,
  output xeu_pkg::cmd_t cmd_o
);

  logic [xeu_pkg::HoldMax-1:0][7:0] held_q, held_d;
  logic [2:0]                       cnt_q, cnt_d;
  logic [xeu_pkg::NumEnt-1:0]       mask_q, mask_d;
  logic [xeu_pkg::NumEnt-1:0]       nxt;
  logic                             hit;
  logic [7:0]                       hit_char;
  logic                             fresh;
  logic [2:0]                       n;
  logic                             accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && (n != 3'd0);

  always_comb begin
    nxt      = '0;
    hit      = 1'b0;
    hit_char = 8'h00;
    for (int e = 0; e < xeu_pkg::NumEnt; e++) begin
      if (mask_q[e] && (cnt_q < xeu_pkg::ent_len(3'(e))) &&
          (xeu_pkg::ent_byte(3'(e), cnt_q) == text_byte_i)) begin
        nxt[e] = 1'b1;
        if (xeu_pkg::ent_len(3'(e)) == cnt_q + 3'd1) begin
          hit      = 1'b1;
          hit_char = xeu_pkg::ent_char(3'(e));
        end
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    mask_d = mask_q;
    held_d = held_q;
    cmd_o  = '0;
    fresh  = 1'b0;
    n      = 3'd0;
    if (cnt_q != 3'd0) begin
      if (hit) begin
        cmd_o.bytes[0] = hit_char;
        n      = 3'd1;
        cnt_d  = 3'd0;
        mask_d = '0;
      end else if ((nxt != '0) && (cnt_q < 3'(xeu_pkg::HoldMax))) begin
        held_d[cnt_q] = text_byte_i;
        cnt_d  = cnt_q + 3'd1;
        mask_d = nxt;
      end else begin
        for (int i = 0; i < xeu_pkg::HoldMax; i++) begin
          if (3'(i) < cnt_q) begin
            cmd_o.bytes[i] = held_q[i];
          end
        end
        n      = cnt_q;
        cnt_d  = 3'd0;
        mask_d = '0;
        fresh  = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end
    if (fresh) begin
      if (text_byte_i == xeu_pkg::AmpChar) begin
        held_d[0] = text_byte_i;
        cnt_d     = 3'd1;
        mask_d    = '1;
      end else begin
        cmd_o.bytes[n] = text_byte_i;
        n = n + 3'd1;
      end
    end
    if (final_byte_i) begin
      for (int i = 0; i < xeu_pkg::HoldMax; i++) begin
        if (3'(i) < cnt_d) begin
          cmd_o.bytes[3'(n + 3'(i))] = held_d[i];
        end
      end
      n      = n + cnt_d;
      cnt_d  = 3'd0;
      mask_d = '0;
    end
    cmd_o.cnt = n;
    cmd_o.fin = final_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 3'd0;
      mask_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(xeu_pkg::HoldMax)) else $error("held count out of range");
  a_mask_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != '0) == (cnt_q != 3'd0)) else $error("candidate mask out of step with held count");

endmodule

// ===== hdl/xeu_queue.sv =====
// Short command queue between matcher and byte sequencer.
// Depends on xeu_pkg.
module xeu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xeu_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output xeu_pkg::cmd_t head_o
);

  xeu_pkg::cmd_t                mem_q [xeu_pkg::QDepth];
  logic [xeu_pkg::QPtrW-1:0]    wr_q, rd_q;
  logic [xeu_pkg::QCntW-1:0]    cnt_q;
  logic                         do_push, do_pop;

  assign full_o       = (cnt_q == xeu_pkg::QCntW'(xeu_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + xeu_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + xeu_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + xeu_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - xeu_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_o |-> (head_o.cnt != 3'd0)) else $error("empty command queued");

endmodule

// ===== hdl/xeu_back.sv =====
// Back end: plays each queued command out one byte per transfer.
// Depends on xeu_pkg.
module xeu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  xeu_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    plain_byte_o,
  output logic          run_end_o,
  output logic          text_end_o
);

  logic [2:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_end_q, text_end_q;
  logic       load, last;

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign last  = (idx_q == head_i.cnt - 3'd1);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= last ? 3'd0 : idx_q + 3'd1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= head_i.bytes[idx_q];
      run_end_q  <= last;
      text_end_q <= last && head_i.fin;
    end
  end

  assign out_valid_o  = valid_q;
  assign plain_byte_o = byte_q;
  assign run_end_o    = run_end_q;
  assign text_end_o   = text_end_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q < head_i.cnt)) else $error("byte index past command");
  a_text_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && text_end_q) |-> run_end_q) else $error("text end without run end");

endmodule

// ===== hdl/xml_entity_unescaper.sv =====
// Top level of the XML predefined-entity unescaper.
// Depends on xeu_pkg, xeu_front, xeu_queue, xeu_back.
//
//   channel   dir  tdata            tuser     tlast
//   s_axis    in   text_byte[7:0]   -         final_byte
//   m_axis    out  plain_byte[7:0]  run_end   text_end
//
// The matcher takes one byte per cycle while the queue has room; results leave
// one byte per cycle while the output is ready. A broken prefix releases up
// to six bytes, which the output side plays out while the two-entry command
// queue keeps input flowing. Input stalls only when the queue is full.
// Reset is asynchronous, active low, and empties hold state and queue.
module xml_entity_unescaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] plain_byte
  output logic       m_axis_tuser_o,   // [0] run_end
  output logic       m_axis_tlast_o
);

  xeu_pkg::cmd_t cmd, head;
  logic          push, full, pop, head_valid;

  xeu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .text_byte_i  (s_axis_tdata_i),
    .final_byte_i (s_axis_tlast_i),
    .q_full_i     (full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  xeu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  xeu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .plain_byte_o (m_axis_tdata_o),
    .run_end_o    (m_axis_tuser_o),
    .text_end_o   (m_axis_tlast_o)
  );

endmodule
